// File: hdl/iepw_pkg.sv
// ----------------------------------------------------------------------------
// iepw_pkg: shared types and codes of the EEPROM page write controller
// Field widths, request and command codes, and the item structures that
// travel between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package iepw_pkg;

   localparam int OP_W    = 2;
   localparam int ADDR_W  = 11;
   localparam int LEN_W   = 12;
   localparam int TICK_W  = 24;
   localparam int KIND_W  = 2;
   localparam int DEV_W   = 7;
   localparam int WORD_W  = 8;
   localparam int WRAP_W  = 3;

   // Request codes.
   localparam logic [OP_W-1:0] OP_START_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_START_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_BUS_IDLE    = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK        = 2'd3;

   // Bus command codes.
   localparam logic [KIND_W-1:0] KIND_PAGE_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE_READ = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POLL_READ  = 2'd2;

   localparam logic [DEV_W-1:0]  DEV_BASE      = 7'h50;
   localparam logic [TICK_W-1:0] TICK_MAX      = 24'hFF_FFFF;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd10000;

   // An input item after address preparation.
   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ADDR_W-1:0] start_address;
      logic [ADDR_W-1:0] start_address_mod;
      logic [ADDR_W-1:0] page_quotient;
      logic [WRAP_W-1:0] wraps;
      logic [LEN_W-1:0]  start_length;
      logic              bus_error;
      logic              bus_refused;
   } item_type;

   // One result item.
   typedef struct packed {
      logic              request_accepted;
      logic              now_idle;
      logic              has_failed;
      logic              command_valid;
      logic [KIND_W-1:0] command_kind;
      logic [DEV_W-1:0]  command_device;
      logic [WORD_W-1:0] command_word_address;
      logic [LEN_W-1:0]  command_length;
      logic [ADDR_W-1:0] command_buffer_offset;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/iepw_req_if.sv
// ----------------------------------------------------------------------------
// iepw_req_if: request channel
// Valid/ready channel that carries one request, bus event or time tick per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface iepw_req_if;
   logic                          valid;
   logic                          ready;
   logic [iepw_pkg::OP_W-1:0]     operation;
   logic [iepw_pkg::ADDR_W-1:0]   start_address;
   logic [iepw_pkg::LEN_W-1:0]    start_length;
   logic                          bus_error;
   logic                          bus_refused;

   modport source (output valid, operation, start_address, start_length, bus_error,
                   bus_refused, input ready);
   modport sink   (input valid, operation, start_address, start_length, bus_error,
                   bus_refused, output ready);
endinterface

`default_nettype wire

// File: hdl/iepw_rsp_if.sv
// ----------------------------------------------------------------------------
// iepw_rsp_if: result channel
// Valid/ready channel that carries one status and command item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface iepw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          request_accepted;
   logic                          now_idle;
   logic                          has_failed;
   logic                          command_valid;
   logic [iepw_pkg::KIND_W-1:0]   command_kind;
   logic [iepw_pkg::DEV_W-1:0]    command_device;
   logic [iepw_pkg::WORD_W-1:0]   command_word_address;
   logic [iepw_pkg::LEN_W-1:0]    command_length;
   logic [iepw_pkg::ADDR_W-1:0]   command_buffer_offset;

   modport source (output valid, request_accepted, now_idle, has_failed, command_valid,
                   command_kind, command_device, command_word_address, command_length,
                   command_buffer_offset, input ready);
   modport sink   (input valid, request_accepted, now_idle, has_failed, command_valid,
                   command_kind, command_device, command_word_address, command_length,
                   command_buffer_offset, output ready);
endinterface

`default_nettype wire

// File: hdl/iepw_csr_if.sv
// ----------------------------------------------------------------------------
// iepw_csr_if: configuration write channel
// Valid/ready channel that writes the busy timeout register.
// ----------------------------------------------------------------------------
`default_nettype none

interface iepw_csr_if;
   logic                          valid;
   logic                          ready;
   logic [iepw_pkg::TICK_W-1:0]   busy_timeout_ticks;

   modport source (output valid, busy_timeout_ticks, input ready);
   modport sink   (input valid, busy_timeout_ticks, output ready);
endinterface

`default_nettype wire

// File: hdl/i2c_eeprom_page_write_controller.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_page_write_controller: EEPROM transfer sequencer
// Turns start requests, bus idle events and time ticks into bus commands
// for an EEPROM with 11-bit addresses, with page splitting and ack polling.
// ----------------------------------------------------------------------------
// Usage: every item on the req channel is a start read, a start write, a
// bus idle event (with the error and refused flags of the bus engine) or a
// time tick. Each item produces exactly one result item on the rsp channel,
// carrying the status flags and, when command_valid is set, the next bus
// command (device, word address, length and buffer offset).
// The csr channel writes the busy timeout in ticks; it is always ready and
// should only be written while no item is in flight.
// The result passes from req to rsp through one input register stage and one
// result register stage, with the sequencer's next-state logic between them.
// Throughput is one item per cycle while the rsp side takes results.
// When the rsp side stalls, the result register holds and the input register
// still takes one more item; req.ready drops only when both stages are full.
// Synchronous reset empties both stages, sets the timeout to 10000 ticks and
// returns the sequencer to idle with all counters cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_page_write_controller #(
   parameter int PAGE_BYTES   = 16,
   parameter int MEMORY_BYTES = 2048
) (
   input  wire logic   clock,
   input  wire logic   reset,
   iepw_req_if.sink    req_chan,
   iepw_rsp_if.source  rsp_chan,
   iepw_csr_if.sink    csr_chan
);

   iepw_pkg::item_type             item_ff, item_in;
   logic                           in_valid_ff, in_valid_in;
   iepw_pkg::rsp_type              out_data_ff, out_data_in;
   logic                           out_valid_ff, out_valid_in;
   logic [iepw_pkg::TICK_W-1:0]    timeout_ff, timeout_in;

   iepw_pkg::rsp_type              core_result;
   logic                           advance;
   logic                           req_take;

   logic [iepw_pkg::ADDR_W-1:0]    prep_addr_mod;
   logic [iepw_pkg::ADDR_W-1:0]    prep_quotient;
   logic [iepw_pkg::WRAP_W-1:0]    prep_wraps;

   // The input stage moves on whenever the result register is free or drains.
   assign advance          = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = 1'b1;

   iepw_addr_prep #(
      .PAGE_BYTES   (PAGE_BYTES),
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_addr_prep (
      .start_address     (req_chan.start_address),
      .start_address_mod (prep_addr_mod),
      .page_quotient     (prep_quotient),
      .wraps             (prep_wraps)
   );

   always_comb begin
      item_in                   = item_ff;
      in_valid_in               = in_valid_ff && !advance;
      if (req_take) begin
         item_in.operation         = req_chan.operation;
         item_in.start_address     = req_chan.start_address;
         item_in.start_address_mod = prep_addr_mod;
         item_in.page_quotient     = prep_quotient;
         item_in.wraps             = prep_wraps;
         item_in.start_length      = req_chan.start_length;
         item_in.bus_error         = req_chan.bus_error;
         item_in.bus_refused       = req_chan.bus_refused;
         in_valid_in               = 1'b1;
      end
   end

   iepw_core #(
      .PAGE_BYTES   (PAGE_BYTES),
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .step               (advance),
      .item               (item_ff),
      .busy_timeout_ticks (timeout_ff),
      .result             (core_result)
   );

   always_comb begin
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (advance) begin
         out_data_in  = core_result;
         out_valid_in = 1'b1;
      end
   end

   assign timeout_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.busy_timeout_ticks
                                                          : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= iepw_pkg::TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         timeout_ff   <= timeout_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid                 = out_valid_ff;
   assign rsp_chan.request_accepted      = out_data_ff.request_accepted;
   assign rsp_chan.now_idle              = out_data_ff.now_idle;
   assign rsp_chan.has_failed            = out_data_ff.has_failed;
   assign rsp_chan.command_valid         = out_data_ff.command_valid;
   assign rsp_chan.command_kind          = out_data_ff.command_kind;
   assign rsp_chan.command_device        = out_data_ff.command_device;
   assign rsp_chan.command_word_address  = out_data_ff.command_word_address;
   assign rsp_chan.command_length        = out_data_ff.command_length;
   assign rsp_chan.command_buffer_offset = out_data_ff.command_buffer_offset;

   // A held input item is never overwritten by a new one.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_take)
      else $error("input item overwritten while stalled");

   // A stalled result keeps the input item waiting in its register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_chan.ready |=> in_valid_ff && out_valid_ff)
      else $error("item lost during a result stall");

   // Every item that advances out of the input stage shows up as a result next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item produced no result");

endmodule

`default_nettype wire

// File: hdl/iepw_addr_prep.sv
// ----------------------------------------------------------------------------
// iepw_addr_prep: start address preparation
// Folds the start address into the memory size and estimates its page
// quotient, so the sequencer only has to finish the page offset.
// ----------------------------------------------------------------------------
`default_nettype none

module iepw_addr_prep #(
   parameter int PAGE_BYTES   = 16,
   parameter int MEMORY_BYTES = 2048
) (
   input  wire logic [iepw_pkg::ADDR_W-1:0] start_address,
   output logic      [iepw_pkg::ADDR_W-1:0] start_address_mod,
   output logic      [iepw_pkg::ADDR_W-1:0] page_quotient,
   output logic      [iepw_pkg::WRAP_W-1:0] wraps
);

   // Address is below 8 times the memory size, so three folds suffice.
   localparam logic [13:0] MEM1 = 14'(MEMORY_BYTES);
   localparam logic [13:0] MEM2 = 14'(2 * MEMORY_BYTES);
   localparam logic [13:0] MEM4 = 14'(4 * MEMORY_BYTES);
   // Reciprocal of the page size, exact for every 11-bit address.
   localparam int          SHIFT = 20;
   localparam logic [31:0] RECIP = 32'((2 ** SHIFT + PAGE_BYTES - 1) / PAGE_BYTES);

   logic [13:0] fold4;
   logic [13:0] fold2;
   logic [13:0] fold1;
   logic [31:0] product;

   always_comb begin
      fold4    = {3'b000, start_address};
      wraps    = '0;
      if (fold4 >= MEM4) begin
         fold4    = fold4 - MEM4;
         wraps[2] = 1'b1;
      end
      fold2 = fold4;
      if (fold2 >= MEM2) begin
         fold2    = fold2 - MEM2;
         wraps[1] = 1'b1;
      end
      fold1 = fold2;
      if (fold1 >= MEM1) begin
         fold1    = fold1 - MEM1;
         wraps[0] = 1'b1;
      end
      start_address_mod = fold1[iepw_pkg::ADDR_W-1:0];
   end

   assign product       = 32'(start_address) * RECIP;
   assign page_quotient = product[SHIFT +: iepw_pkg::ADDR_W];

endmodule

`default_nettype wire

// File: hdl/iepw_core.sv
// ----------------------------------------------------------------------------
// iepw_core: transfer sequencer
// Holds the transfer state and computes the result item and next state for
// the item in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module iepw_core #(
   parameter int PAGE_BYTES   = 16,
   parameter int MEMORY_BYTES = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire iepw_pkg::item_type            item,
   input  wire logic [iepw_pkg::TICK_W-1:0]   busy_timeout_ticks,
   output iepw_pkg::rsp_type                  result
);

   localparam int OFF_W  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
   localparam int ROOM_W = $clog2(PAGE_BYTES + 1);
   localparam int AW     = iepw_pkg::ADDR_W;
   localparam int LW     = iepw_pkg::LEN_W;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_FAIL  = 3'd1;
   localparam logic [2:0] PH_READ  = 3'd2;
   localparam logic [2:0] PH_WRITE = 3'd3;
   localparam logic [2:0] PH_BUSY  = 3'd4;

   localparam logic [ROOM_W-1:0] PAGE_R = ROOM_W'(PAGE_BYTES);
   localparam logic [LW-1:0]     MEM_L  = LW'(MEMORY_BYTES);

   // Page offset of k times the memory size, for k wraps of the start address.
   localparam logic [OFF_W-1:0] WRAP_OFF [8] = '{
      OFF_W'(0),
      OFF_W'((1 * MEMORY_BYTES) % PAGE_BYTES),
      OFF_W'((2 * MEMORY_BYTES) % PAGE_BYTES),
      OFF_W'((3 * MEMORY_BYTES) % PAGE_BYTES),
      OFF_W'((4 * MEMORY_BYTES) % PAGE_BYTES),
      OFF_W'((5 * MEMORY_BYTES) % PAGE_BYTES),
      OFF_W'((6 * MEMORY_BYTES) % PAGE_BYTES),
      OFF_W'((7 * MEMORY_BYTES) % PAGE_BYTES)
   };

   logic [2:0]                  phase_ff,    phase_in;
   logic                        entering_ff, entering_in;
   logic [AW-1:0]               addr_ff,     addr_in;
   logic [OFF_W-1:0]            page_off_ff, page_off_in;
   logic [LW-1:0]               bytes_ff,    bytes_in;
   logic [AW-1:0]               buf_pos_ff,  buf_pos_in;
   logic [iepw_pkg::TICK_W-1:0] elapsed_ff,  elapsed_in;

   logic [2:0]                  phase_eff;
   logic [19:0]                 quot_page;
   logic [AW-1:0]               start_rem;
   logic [OFF_W-1:0]            start_adj;
   logic [OFF_W-1:0]            start_off;
   logic [ROOM_W-1:0]           room;
   logic [LW-1:0]               chunk;
   logic [ROOM_W-1:0]           off_sum;
   logic [OFF_W-1:0]            off_fold;
   logic [OFF_W-1:0]            off_wrapped;
   logic [LW-1:0]               addr_sum;
   logic [iepw_pkg::TICK_W-1:0] elapsed_eff;

   // Page offset of the folded start address.
   assign quot_page = 20'(item.page_quotient) * 20'(PAGE_BYTES);
   assign start_rem = item.start_address - quot_page[AW-1:0];
   assign start_adj = WRAP_OFF[item.wraps];
   assign start_off = (start_rem[OFF_W-1:0] >= start_adj)
                    ? start_rem[OFF_W-1:0] - start_adj
                    : OFF_W'(ROOM_W'(start_rem[OFF_W-1:0]) + PAGE_R - ROOM_W'(start_adj));

   // Next page write chunk and where it leaves the address.
   assign room     = PAGE_R - ROOM_W'(page_off_ff);
   assign chunk    = (bytes_ff < LW'(room)) ? bytes_ff : LW'(room);
   assign off_sum  = ROOM_W'(page_off_ff) + ROOM_W'(chunk);
   assign off_fold = (off_sum == PAGE_R) ? '0 : OFF_W'(off_sum);
   assign off_wrapped = (off_fold >= WRAP_OFF[1])
                      ? off_fold - WRAP_OFF[1]
                      : OFF_W'(ROOM_W'(off_fold) + PAGE_R - ROOM_W'(WRAP_OFF[1]));
   assign addr_sum = LW'(addr_ff) + chunk;

   assign elapsed_eff = entering_ff ? '0 : elapsed_ff;

   always_comb begin
      phase_in    = phase_ff;
      entering_in = entering_ff;
      addr_in     = addr_ff;
      page_off_in = page_off_ff;
      bytes_in    = bytes_ff;
      buf_pos_in  = buf_pos_ff;
      elapsed_in  = elapsed_ff;
      phase_eff   = phase_ff;
      result      = '0;
      if (step) begin
         unique case (item.operation) inside
            iepw_pkg::OP_START_READ, iepw_pkg::OP_START_WRITE: begin
               if (phase_ff == PH_IDLE || phase_ff == PH_FAIL) begin
                  phase_in    = (item.operation == iepw_pkg::OP_START_READ)
                              ? PH_READ : PH_WRITE;
                  entering_in = 1'b1;
                  addr_in     = item.start_address_mod;
                  page_off_in = start_off;
                  bytes_in    = item.start_length;
                  buf_pos_in  = '0;
                  result.request_accepted = 1'b1;
               end
            end
            iepw_pkg::OP_TICK: begin
               if (elapsed_ff != iepw_pkg::TICK_MAX) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            iepw_pkg::OP_BUS_IDLE: begin
               // A bus error outside ack polling fails before anything else.
               phase_eff = (item.bus_error && phase_ff != PH_BUSY) ? PH_FAIL : phase_ff;
               phase_in  = phase_eff;
               unique case (phase_eff) inside
                  PH_READ: begin
                     if (entering_ff && bytes_ff != '0) begin
                        if (item.bus_refused) begin
                           phase_in = PH_FAIL;
                        end else begin
                           result.command_valid         = 1'b1;
                           result.command_kind          = iepw_pkg::KIND_WRITE_READ;
                           result.command_device        = iepw_pkg::DEV_BASE
                                                        | {4'b0000, addr_ff[10:8]};
                           result.command_word_address  = addr_ff[7:0];
                           result.command_length        = bytes_ff;
                           result.command_buffer_offset = buf_pos_ff;
                        end
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_WRITE: begin
                     phase_in = PH_IDLE;
                     if (bytes_ff != '0) begin
                        if (item.bus_refused) begin
                           phase_in = PH_FAIL;
                        end else begin
                           result.command_valid         = 1'b1;
                           result.command_kind          = iepw_pkg::KIND_PAGE_WRITE;
                           result.command_device        = iepw_pkg::DEV_BASE
                                                        | {4'b0000, addr_ff[10:8]};
                           result.command_word_address  = addr_ff[7:0];
                           result.command_length        = chunk;
                           result.command_buffer_offset = buf_pos_ff;
                           if (addr_sum >= MEM_L) begin
                              addr_in     = AW'(addr_sum - MEM_L);
                              page_off_in = off_wrapped;
                           end else begin
                              addr_in     = addr_sum[AW-1:0];
                              page_off_in = off_fold;
                           end
                           bytes_in   = bytes_ff - chunk;
                           buf_pos_in = buf_pos_ff + chunk[AW-1:0];
                           phase_in   = PH_BUSY;
                        end
                     end
                  end
                  PH_BUSY: begin
                     elapsed_in = elapsed_eff;
                     if (entering_ff || item.bus_error) begin
                        if (elapsed_eff >= busy_timeout_ticks || item.bus_refused) begin
                           phase_in = PH_FAIL;
                        end else begin
                           result.command_valid         = 1'b1;
                           result.command_kind          = iepw_pkg::KIND_POLL_READ;
                           result.command_device        = iepw_pkg::DEV_BASE;
                           result.command_word_address  = '0;
                           result.command_length        = LW'(1);
                           result.command_buffer_offset = '0;
                        end
                     end else begin
                        phase_in = PH_WRITE;
                     end
                  end
                  PH_IDLE, PH_FAIL: begin
                     phase_in = phase_eff;
                  end
                  default: begin
                     phase_in = PH_FAIL;
                  end
               endcase
               entering_in     = (phase_in != phase_ff);
               result.now_idle = (phase_in == PH_IDLE);
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
      result.has_failed = (phase_in == PH_FAIL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         entering_ff <= 1'b1;
         addr_ff     <= '0;
         page_off_ff <= '0;
         bytes_ff    <= '0;
         buf_pos_ff  <= '0;
         elapsed_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         entering_ff <= entering_in;
         addr_ff     <= addr_in;
         page_off_ff <= page_off_in;
         bytes_ff    <= bytes_in;
         buf_pos_ff  <= buf_pos_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   // The folded address and its page offset always stay in range.
   assert property (@(posedge clock) disable iff (reset)
      LW'(addr_ff) < MEM_L && ROOM_W'(page_off_ff) < PAGE_R)
      else $error("address or page offset out of range");

   // A tick never moves the sequencer or the address.
   assert property (@(posedge clock) disable iff (reset)
      step && item.operation == iepw_pkg::OP_TICK
      |=> $stable(phase_ff) && $stable(addr_ff) && $stable(bytes_ff))
      else $error("tick changed the transfer state");

   // An accepted page write always leads into ack polling.
   assert property (@(posedge clock) disable iff (reset)
      step && item.operation == iepw_pkg::OP_BUS_IDLE && phase_ff == PH_WRITE
      && !item.bus_error && !item.bus_refused && bytes_ff != '0
      |=> phase_ff == PH_BUSY && entering_ff)
      else $error("page write did not enter ack polling");

   // A command is never issued together with a failure or a return to idle.
   assert property (@(posedge clock) disable iff (reset)
      step && result.command_valid |-> !result.has_failed && phase_in != PH_IDLE)
      else $error("command issued while failing or idle");

endmodule

`default_nettype wire
